FILE: design/assert_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CSVT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/csvt_pkg.sv
package csvt_pkg;

    // Field counter cap limit and derived cap (the counter is 8 bits wide).
    localparam int MAX_FIELDS = 255;
    localparam logic [8:0] FIELD_CAP = (MAX_FIELDS < 255) ? 9'(MAX_FIELDS) : 9'd255;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int FIELD_W = 8;
    localparam logic [FIELD_W-1:0] EXPECTED_RESET = 8'd4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_EOL  = 1'b1;

    typedef enum logic [1:0] {
        FS_START    = 2'd0,
        FS_UNQUOTED = 2'd1,
        FS_QUOTED   = 2'd2,
        FS_CLOSED   = 2'd3
    } fstate_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_QUOTE_UNQ   = 2'd1,
        ERR_AFTER_CLOSE = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_LINE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_QUOTE_UNQ   = 3'd1,
        ST_AFTER_CLOSE = 3'd2,
        ST_UNCLOSED    = 3'd3,
        ST_COUNT       = 3'd4,
        ST_EMPTY       = 3'd5
    } status_t;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic [FIELD_W-1:0] field_index;
        status_t            line_status;
        logic               last;
    } result_t;

    // One queue entry holds every result of one input transaction.
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_head_t;

endpackage

FILE: design/csv_line_tokenizer_top.sv
// An accepted item's results are queued, then leave one at a time via the output register.
// Throughput: one input transaction per cycle unless stalled; the back end drains one
// result per cycle unless result_stall, so a byte releasing a held CR gives two results.
// Stall on the input rises only when the QUEUE_DEPTH-entry result queue is full.
// Reset (rst_n, asynchronous, active low) empties the queue, returns the field machine
// to start of field and sets expected_fields to 4.
module csv_line_tokenizer_top #(
    parameter int QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  csvt_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_stall,
    output csvt_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [csvt_pkg::FIELD_W-1:0] cfg_data
);
    import csvt_pkg::*;

    // The front end owns the field machine and the expected_fields register. Every
    // input transaction that yields results pushes one queue entry holding one or two
    // results, so the front end never waits on the consumer while the queue has room.
    q_push_t push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    csvt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push)
    );

    // The queue decouples the two halves, so either side can stall on its own.
    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // The back end serializes each entry into single result transactions
    // through a registered output stage.
    csvt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: design/csvt_front.sv
`include "assert_macros.svh"

module csvt_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  csvt_pkg::item_t                       item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [csvt_pkg::FIELD_W-1:0]          cfg_data,
    input  logic                                  q_full,
    output csvt_pkg::q_push_t                     push
);
    import csvt_pkg::*;

    typedef struct packed {
        fstate_t            fstate;
        err_t               err;
        logic [FIELD_W-1:0] count;
        logic               has_bytes;
    } tok_t;

    typedef struct packed {
        tok_t    st;
        logic    emit;
        result_t res;
    } feed_t;

    localparam tok_t TOK_RESET = '{fstate: FS_START, err: ERR_NONE,
                                   count: '0, has_bytes: 1'b0};

    tok_t               tok_reg, tok_next, tok_mid;
    logic               cr_pending_reg, cr_pending_next;
    logic [FIELD_W-1:0] expected_reg, expected_next;
    feed_t              f_cr, f_b;
    logic               accept, is_data, byte_is_cr, emit_cr, emit_b;

    function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] c);
        return (c < FIELD_CAP[FIELD_W-1:0]) ? c + 1'b1 : c;
    endfunction

    function automatic result_t mk_res(kind_t k, logic [7:0] b, logic [FIELD_W-1:0] idx);
        result_t r;
        r = '0;
        r.kind        = k;
        r.out_byte    = b;
        r.field_index = idx;
        r.line_status = ST_OK;
        r.last        = 1'b0;
        return r;
    endfunction

    // One byte through the field machine.
    function automatic feed_t feed(tok_t st, logic [7:0] b);
        feed_t o;
        logic  comma, quote;
        comma  = (b == CH_COMMA);
        quote  = (b == CH_QUOTE);
        o.st   = st;
        o.emit = 1'b0;
        o.res  = '0;
        if (st.err == ERR_NONE)
        begin
            o.st.has_bytes = 1'b1;
            case (st.fstate)
                FS_START:
                begin
                    if (comma)
                    begin
                        o.emit     = 1'b1;
                        o.res      = mk_res(KIND_FIELD, 8'd0, st.count);
                        o.st.count = bump(st.count);
                    end
                    else if (quote)
                    begin
                        o.st.fstate = FS_QUOTED;
                    end
                    else
                    begin
                        o.emit      = 1'b1;
                        o.res       = mk_res(KIND_BYTE, b, st.count);
                        o.st.fstate = FS_UNQUOTED;
                    end
                end
                FS_UNQUOTED:
                begin
                    if (comma)
                    begin
                        o.emit      = 1'b1;
                        o.res       = mk_res(KIND_FIELD, 8'd0, st.count);
                        o.st.count  = bump(st.count);
                        o.st.fstate = FS_START;
                    end
                    else if (quote)
                    begin
                        o.st.err = ERR_QUOTE_UNQ;
                    end
                    else
                    begin
                        o.emit = 1'b1;
                        o.res  = mk_res(KIND_BYTE, b, st.count);
                    end
                end
                FS_QUOTED:
                begin
                    if (quote)
                    begin
                        o.st.fstate = FS_CLOSED;
                    end
                    else
                    begin
                        o.emit = 1'b1;
                        o.res  = mk_res(KIND_BYTE, b, st.count);
                    end
                end
                FS_CLOSED:
                begin
                    if (comma)
                    begin
                        o.emit      = 1'b1;
                        o.res       = mk_res(KIND_FIELD, 8'd0, st.count);
                        o.st.count  = bump(st.count);
                        o.st.fstate = FS_START;
                    end
                    else if (quote)
                    begin
                        o.emit      = 1'b1;
                        o.res       = mk_res(KIND_BYTE, CH_QUOTE, st.count);
                        o.st.fstate = FS_QUOTED;
                    end
                    else
                    begin
                        o.st.err = ERR_AFTER_CLOSE;
                    end
                end
                default:
                begin
                    o.st = st;
                end
            endcase
        end
        return o;
    endfunction

    function automatic status_t line_status(tok_t st, logic [FIELD_W-1:0] expected);
        logic [FIELD_W:0] total;
        status_t          s;
        total = {1'b0, st.count} + 1'b1;
        if (!st.has_bytes)
            s = ST_EMPTY;
        else if (st.err == ERR_QUOTE_UNQ)
            s = ST_QUOTE_UNQ;
        else if (st.err == ERR_AFTER_CLOSE)
            s = ST_AFTER_CLOSE;
        else if (st.fstate == FS_QUOTED)
            s = ST_UNCLOSED;
        else if (total > FIELD_CAP || total != {1'b0, expected})
            s = ST_COUNT;
        else
            s = ST_OK;
        return s;
    endfunction

    assign item_stall = q_full;
    assign cfg_ready  = 1'b1;
    assign accept     = item_valid && !item_stall;
    assign is_data    = (item.action == ACT_DATA);
    assign byte_is_cr = (item.byte_value == CH_CR);

    // A held carriage return is fed first, then the new byte.
    always_comb
    begin
        f_cr    = feed(tok_reg, CH_CR);
        tok_mid = cr_pending_reg ? f_cr.st : tok_reg;
        f_b     = feed(tok_mid, item.byte_value);
        emit_cr = cr_pending_reg && f_cr.emit;
        emit_b  = !byte_is_cr && f_b.emit;
    end

    // Next state.
    always_comb
    begin
        tok_next        = tok_reg;
        cr_pending_next = cr_pending_reg;
        expected_next   = expected_reg;
        if (cfg_valid && cfg_ready)
        begin
            expected_next = cfg_data;
        end
        if (accept)
        begin
            if (!is_data)
            begin
                tok_next        = TOK_RESET;
                cr_pending_next = 1'b0;
            end
            else if (tok_reg.err == ERR_NONE)
            begin
                tok_next        = byte_is_cr ? tok_mid : f_b.st;
                cr_pending_next = byte_is_cr && (tok_mid.err == ERR_NONE);
            end
        end
    end

    // Queue entry.
    always_comb
    begin
        push = '0;
        if (accept)
        begin
            if (!is_data)
            begin
                push.valid                  = 1'b1;
                push.entry.two              = 1'b0;
                push.entry.res0             = mk_res(KIND_LINE, 8'd0,
                                                     tok_reg.has_bytes ? tok_reg.count : '0);
                push.entry.res0.line_status = line_status(tok_reg, expected_reg);
                push.entry.res0.last        = 1'b1;
            end
            else if (tok_reg.err == ERR_NONE)
            begin
                push.valid      = emit_cr || emit_b;
                push.entry.two  = emit_cr && emit_b;
                push.entry.res0 = emit_cr ? f_cr.res : f_b.res;
                push.entry.res1 = f_b.res;
                if (emit_cr && emit_b)
                    push.entry.res1.last = 1'b1;
                else
                    push.entry.res0.last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= TOK_RESET;
            cr_pending_reg <= 1'b0;
            expected_reg   <= EXPECTED_RESET;
        end
        else
        begin
            tok_reg        <= tok_next;
            cr_pending_reg <= cr_pending_next;
            expected_reg   <= expected_next;
        end
    end

    `CSVT_ASSERT(a_cr_no_err, clk, rst_n, cr_pending_reg |-> tok_reg.err == ERR_NONE, "held CR with error")
    `CSVT_ASSERT(a_count_bytes, clk, rst_n, (tok_reg.count != '0) |-> tok_reg.has_bytes, "fields counted without bytes")

endmodule

FILE: design/csvt_queue.sv
`include "assert_macros.svh"

module csvt_queue #(
    parameter int DEPTH = csvt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csvt_pkg::q_push_t push,
    input  logic              pop,
    output logic              full,
    output csvt_pkg::q_head_t head
);
    import csvt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.valid) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CSVT_NEVER(a_no_overflow, clk, rst_n, push.valid && full, "push into full queue")
    `CSVT_NEVER(a_no_underflow, clk, rst_n, pop && !head.valid, "pop from empty queue")

endmodule

FILE: design/csvt_back.sv
`include "assert_macros.svh"

module csvt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  csvt_pkg::q_head_t head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output csvt_pkg::result_t result
);
    import csvt_pkg::*;

    logic    sel_reg, sel_next;
    logic    valid_reg, valid_next;
    result_t result_reg, result_next;
    logic    load;

    // The output register loads a valid head when empty or taken.
    assign load = head.valid && (!valid_reg || !result_stall);

    always_comb
    begin
        sel_next    = sel_reg;
        result_next = result_reg;
        pop         = 1'b0;
        valid_next  = valid_reg && result_stall;
        if (load)
        begin
            valid_next  = 1'b1;
            result_next = sel_reg ? head.entry.res1 : head.entry.res0;
            pop         = sel_reg || !head.entry.two;
            sel_next    = !sel_reg && head.entry.two;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    `CSVT_ASSERT(a_sel_two, clk, rst_n, sel_reg |-> head.valid && head.entry.two, "second result without pair")

endmodule
